>>> hw/rtl/assert_macros.svh
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KIL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KIL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/kil_pkg.sv
// Types and constants shared by the keyframe interval lookup modules.
package kil_pkg;

	localparam logic [1:0] KIND_CLEAR  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam int KEY_W    = 32;
	localparam int RATIO_W  = 17;
	localparam int PIDX_W   = 8;
	localparam int NIDX_W   = 7;
	localparam int IN_W     = 32;
	localparam int OUT_W    = 96;
	localparam int USER_W   = 3;

	localparam int DIV_STEPS = RATIO_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef logic signed [KEY_W-1:0] key_t;

	typedef struct packed {
		logic shift;
		logic load;
	} kil_cell_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kil_div_stat_t;

endpackage

>>> hw/rtl/keyframe_interval_lookup_top.sv
// Keyframe interval lookup: a clear or an append word is handled in the idle state; a
// query rotates the whole ring of MAX_KEYS key cells once past its head cell, picks
// the case, runs the bit-serial divider for the blend ratio when the frame lies inside
// a bracket of unequal keys, and loads the output register, waiting there while the
// output stalls. No new word is taken until the query has finished. Only keys below
// the fill count are ever looked at, so the ring needs no reset.
module keyframe_interval_lookup_top #(
	parameter int MAX_KEYS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// frame_value[31:0]
	input  logic [kil_pkg::IN_W-1:0]      s_tdata,
	// kind[1:0], setting_mode[2]
	input  logic [kil_pkg::USER_W-1:0]    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// prev_index[7:0], prev_time[39:8], next_index[46:40], next_time[78:47],
	// blend_ratio[95:79]
	output logic [kil_pkg::OUT_W-1:0]     m_tdata
);

	localparam int CW = $clog2(MAX_KEYS + 1);
	localparam int AW = $clog2(MAX_KEYS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE,
		ST_DIV,
		ST_FINISH
	} state_t;

	state_t                         state_q;
	logic [CW-1:0]                  count_q;
	logic [AW-1:0]                  step_q;
	kil_pkg::key_t                  frame_q;
	logic                           setting_q;
	kil_pkg::key_t                  first_q;
	kil_pkg::key_t                  last_q;
	kil_pkg::key_t                  prev_q;
	logic                           found_q;
	logic [AW-1:0]                  fidx_q;
	kil_pkg::key_t                  a_q;
	kil_pkg::key_t                  b_q;
	logic [kil_pkg::PIDX_W-1:0]     res_pidx_q;
	kil_pkg::key_t                  res_ptime_q;
	logic [kil_pkg::NIDX_W-1:0]     res_nidx_q;
	kil_pkg::key_t                  res_ntime_q;
	logic [kil_pkg::RATIO_W-1:0]    res_ratio_q;
	logic                           m_tvalid_q;
	logic [kil_pkg::OUT_W-1:0]      m_tdata_q;

	kil_pkg::key_t                  ring [MAX_KEYS];
	kil_pkg::kil_cell_ctrl_t        cell_ctrl [MAX_KEYS];
	kil_pkg::key_t                  head;
	kil_pkg::key_t                  in_frame;
	logic [1:0]                     in_kind;
	logic                           in_fire;
	logic                           append_fire;
	logic                           shift_en;
	logic                           div_start;
	logic [kil_pkg::KEY_W-1:0]      num;
	logic [kil_pkg::KEY_W-1:0]      den;
	kil_pkg::kil_div_stat_t         div_stat;
	logic [kil_pkg::RATIO_W-1:0]    div_quo;
	logic                           is_start;
	logic                           is_last;
	logic [31:0]                    fidx_ext;
	logic [31:0]                    nidx_ext;
	logic [31:0]                    last_ext;

	assign in_frame    = s_tdata;
	assign in_kind     = s_tuser[1:0];
	assign s_tready    = (state_q == ST_IDLE);
	assign in_fire     = s_tvalid && s_tready;
	assign append_fire = in_fire && (in_kind == kil_pkg::KIND_APPEND)
		&& (count_q < CW'(MAX_KEYS));
	assign shift_en    = (state_q == ST_SCAN);
	assign head        = ring[0];

	// The ring turns toward cell zero, so at scan step j the head holds key j.
	for (genvar k = 0; k < MAX_KEYS; k++) begin : g_cell
		assign cell_ctrl[k].shift = shift_en;
		assign cell_ctrl[k].load  = append_fire && (count_q == CW'(k));
		kil_cell u_cell (
			.clk      (clk),
			.ctrl     (cell_ctrl[k]),
			.load_val (in_frame),
			.shift_in (ring[(k + 1) % MAX_KEYS]),
			.key_out  (ring[k])
		);
	end

	// Both differences are non-negative inside a bracket and fit in 32 unsigned bits.
	assign num = frame_q - a_q;
	assign den = b_q - a_q;

	assign is_start  = (count_q == '0) || (frame_q <= first_q);
	assign is_last   = (frame_q > last_q);
	assign div_start = (state_q == ST_RESOLVE) && !is_start && !is_last && found_q
		&& (den != '0);

	assign fidx_ext = 32'(fidx_q);
	assign nidx_ext = fidx_ext + 32'd1;
	assign last_ext = setting_q ? 32'(count_q) : (32'(count_q) - 32'd1);

	kil_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			step_q     <= '0;
			found_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						case (in_kind)
							kil_pkg::KIND_CLEAR: begin
								count_q <= '0;
							end
							kil_pkg::KIND_APPEND: begin
								if (append_fire) begin
									count_q <= count_q + CW'(1);
								end
							end
							kil_pkg::KIND_QUERY: begin
								frame_q   <= in_frame;
								setting_q <= s_tuser[2];
								step_q    <= '0;
								found_q   <= 1'b0;
								state_q   <= ST_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (step_q == '0) begin
						first_q <= head;
					end
					if ((count_q != '0) && (CW'(step_q) == count_q - CW'(1))) begin
						last_q <= head;
					end
					// First adjacent pair that brackets the frame wins.
					if ((step_q != '0) && (CW'(step_q) < count_q) && !found_q
						&& (prev_q <= frame_q) && (head >= frame_q)) begin
						found_q <= 1'b1;
						fidx_q  <= step_q - AW'(1);
						a_q     <= prev_q;
						b_q     <= head;
					end
					prev_q <= head;
					step_q <= step_q + AW'(1);
					if (step_q == AW'(MAX_KEYS - 1)) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					res_ratio_q <= '0;
					if (is_start || (!is_last && !found_q)) begin
						res_pidx_q  <= setting_q ? '1 : '0;
						res_ptime_q <= '0;
						res_nidx_q  <= '0;
						res_ntime_q <= '0;
						state_q     <= ST_FINISH;
					end else if (is_last) begin
						res_pidx_q  <= last_ext[kil_pkg::PIDX_W-1:0];
						res_ptime_q <= last_q;
						res_nidx_q  <= last_ext[kil_pkg::NIDX_W-1:0];
						res_ntime_q <= last_q;
						state_q     <= ST_FINISH;
					end else begin
						res_pidx_q  <= fidx_ext[kil_pkg::PIDX_W-1:0];
						res_ptime_q <= a_q;
						res_nidx_q  <= nidx_ext[kil_pkg::NIDX_W-1:0];
						res_ntime_q <= b_q;
						state_q     <= div_start ? ST_DIV : ST_FINISH;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						res_ratio_q <= div_quo;
						state_q     <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q  <= {res_ratio_q, res_ntime_q, res_nidx_q,
							res_ptime_q, res_pidx_q};
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

>>> hw/rtl/kil_cell.sv
// One storage cell of the key ring: holds a key time and passes it to its neighbor.
module kil_cell (
	input  logic                    clk,
	input  kil_pkg::kil_cell_ctrl_t ctrl,
	input  kil_pkg::key_t           load_val,
	input  kil_pkg::key_t           shift_in,
	output kil_pkg::key_t           key_out
);

	kil_pkg::key_t key_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= shift_in;
		end else if (ctrl.load) begin
			key_q <= load_val;
		end
	end

	assign key_out = key_q;

endmodule

>>> hw/rtl/kil_divider.sv
// Restoring divider for the Q1.16 blend ratio, one quotient bit per cycle.
module kil_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [kil_pkg::KEY_W-1:0]     num,
	input  logic [kil_pkg::KEY_W-1:0]     den,
	output kil_pkg::kil_div_stat_t        stat,
	output logic [kil_pkg::RATIO_W-1:0]   quo
);

	logic [kil_pkg::KEY_W:0]          r_q;
	logic [kil_pkg::KEY_W-1:0]        den_q;
	logic [kil_pkg::RATIO_W-1:0]      q_q;
	logic [kil_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic                             busy_q;
	logic                             done_q;
	logic [kil_pkg::KEY_W:0]          trial;
	logic [kil_pkg::KEY_W:0]          den_ext;
	logic                             ge;

	// The numerator never exceeds the divisor, so the first step compares
	// without a shift and the quotient fits in seventeen bits.
	assign trial   = (cnt_q == '0) ? r_q : {r_q[kil_pkg::KEY_W-1:0], 1'b0};
	assign den_ext = {1'b0, den_q};
	assign ge      = (trial >= den_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				r_q    <= {1'b0, num};
				den_q  <= den;
				q_q    <= '0;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q <= ge ? (trial - den_ext) : trial;
				q_q <= {q_q[kil_pkg::RATIO_W-2:0], ge};
				if (cnt_q == kil_pkg::DIV_CNT_W'(kil_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + kil_pkg::DIV_CNT_W'(1);
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = q_q;

endmodule

>>> hw/rtl/kil_checker.sv
// Port-level checks for the keyframe interval lookup, bound to its top level.
`include "assert_macros.svh"

module kil_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic [kil_pkg::USER_W-1:0]  s_tuser,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [kil_pkg::OUT_W-1:0]   m_tdata
);

	logic                          query_fire;
	logic                          out_stall;
	logic                          ratio_set;
	logic [kil_pkg::RATIO_W-1:0]   out_ratio;
	logic [kil_pkg::NIDX_W-1:0]    out_pidx_lo;
	logic [kil_pkg::NIDX_W-1:0]    out_nidx;

	assign query_fire  = s_tvalid && s_tready && (s_tuser[1:0] == kil_pkg::KIND_QUERY);
	assign out_stall   = m_tvalid && !m_tready;
	assign out_ratio   = m_tdata[95:79];
	assign out_pidx_lo = m_tdata[6:0];
	assign out_nidx    = m_tdata[46:40];
	assign ratio_set   = m_tvalid && (out_ratio != '0);

	`KIL_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, m_tvalid, "stalled word dropped")
	`KIL_ASSERT_IMP(a_ratio_range, clk, arst_n, m_tvalid, out_ratio <= 17'd65536, "ratio above one")
	`KIL_ASSERT_NXT(a_query_busy, clk, arst_n, query_fire, !s_tready, "query did not hold block")
	`KIL_ASSERT_IMP(a_interior_idx, clk, arst_n, ratio_set, out_nidx == out_pidx_lo + 7'd1, "bad pair")

endmodule

bind keyframe_interval_lookup_top kil_checker u_kil_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
